FILE: rtl/mmrn_pkg.sv
// shared payload types, kind codes and sequencer states for the region normaliser
package mmrn_pkg;

    typedef struct packed {
        logic [63:0] region_base;
        logic [63:0] region_length;
        logic [31:0] region_kind_in;
        logic        map_start;
    } t_in_item;

    typedef struct packed {
        logic [63:0] out_base;
        logic [63:0] out_length;
        logic [2:0]  out_kind;
        logic [8:0]  out_index;
        logic [63:0] highest_end;
        logic        last_of_run;
        logic        capacity_flag;
    } t_out_item;

    // dense kind codes on the output
    localparam logic [2:0] KIND_AVAIL    = 3'd0;
    localparam logic [2:0] KIND_RESERVED = 3'd1;
    localparam logic [2:0] KIND_ACPI     = 3'd2;
    localparam logic [2:0] KIND_NVS      = 3'd3;
    localparam logic [2:0] KIND_BAD      = 3'd4;
    localparam logic [2:0] KIND_BOOT     = 3'd5;
    localparam logic [2:0] KIND_UNKNOWN  = 3'd6;

    // loader type codes on the input
    localparam logic [31:0] LDR_AVAIL    = 32'd1;
    localparam logic [31:0] LDR_RESERVED = 32'd2;
    localparam logic [31:0] LDR_ACPI     = 32'd3;
    localparam logic [31:0] LDR_NVS      = 32'd4;
    localparam logic [31:0] LDR_BAD      = 32'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_EMIT0,
        ST_EMIT1
    } t_state;

    // control from the sequencer to the containment unit
    typedef struct packed {
        logic clear;
        logic vld;
    } t_cmp_ctrl;

    function automatic logic [2:0] kind_of(input logic [31:0] ldr);
        logic [2:0] k;
        case (ldr)
            LDR_AVAIL:    k = KIND_AVAIL;
            LDR_RESERVED: k = KIND_RESERVED;
            LDR_ACPI:     k = KIND_ACPI;
            LDR_NVS:      k = KIND_NVS;
            LDR_BAD:      k = KIND_BAD;
            default:      k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

endpackage

FILE: rtl/mmrn_entry_store.sv
// store of earlier raw entries (base and end) with one write and one registered read port
module mmrn_entry_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [63:0]   i_wbase,
    input  logic [63:0]   i_wend,
    input  logic [AW-1:0] i_raddr,
    output logic [63:0]   o_rbase,
    output logic [63:0]   o_rend
);

    logic [63:0] r_bases [DEPTH];
    logic [63:0] r_ends  [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_bases[i_waddr] <= i_wbase;
            r_ends[i_waddr]  <= i_wend;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rbase <= r_bases[i_raddr];
        o_rend  <= r_ends[i_raddr];
    end

endmodule

FILE: rtl/mmrn_contain_unit.sv
// shared containment compare, one stored entry per cycle, sticky result
module mmrn_contain_unit (
    input  logic                  i_clk,
    input  mmrn_pkg::t_cmp_ctrl   i_ctrl,
    input  logic [63:0]           i_seen_base,
    input  logic [63:0]           i_seen_end,
    input  logic [63:0]           i_base,
    input  logic [63:0]           i_end,
    output logic                  o_contained
);

    logic r_contained;
    logic hit;

    // strictly inside an earlier entry
    assign hit = (i_seen_base < i_base) && (i_end < i_seen_end);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.clear) begin
            r_contained <= 1'b0;
        end else if (i_ctrl.vld && hit) begin
            r_contained <= 1'b1;
        end
    end

    assign o_contained = r_contained;

endmodule

FILE: rtl/memory_map_region_normalizer.sv
// top level: sequencer, counters and output register of the region normaliser
// Each accepted memory-map entry keeps the input stalled while the sequencer compares it with the N entries
// already stored for the current map (at most ENTRY_DEPTH) through the single containment comparator
// (the one read port of the entry store is registered, so the last compare lands in the cycle after
// the last read), then passes a decision state and, unless the entry is contained and dropped, one
// emit state per emitted region (one or two), each waiting until the output register is free.
// Output stalls thus lengthen the stall of the input. Configuration writes are always taken.
module memory_map_region_normalizer #(
    parameter int ENTRY_DEPTH  = 64,
    parameter int OUT_CAPACITY = 512
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  mmrn_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output mmrn_pkg::t_out_item  o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [31:0]          i_cfg_data
);

    localparam int AW  = (ENTRY_DEPTH > 1) ? $clog2(ENTRY_DEPTH) : 1;
    localparam int SCW = $clog2(ENTRY_DEPTH + 1);
    localparam int ECW = $clog2(OUT_CAPACITY + 1);

    mmrn_pkg::t_state    r_state, n_state;
    logic [SCW-1:0]      r_seen_count, n_seen_count;
    logic [ECW-1:0]      r_emit_cnt, n_emit_cnt;
    logic [63:0]         r_highest, n_highest;
    logic [31:0]         r_bse;
    logic [SCW-1:0]      r_scan_idx, n_scan_idx;
    logic                r_cmp_vld, n_cmp_vld;
    logic                r_out_vld, n_out_vld;
    mmrn_pkg::t_out_item r_out, n_out;

    logic [63:0]         r_base, r_len, r_end, r_delta;
    logic [2:0]          r_kind;
    logic                r_flag, r_split, r_boot;
    logic [63:0]         n_delta;
    logic                n_flag, n_split, n_boot;

    logic                accept, load_ok, scan_more, store_room, contained;
    logic                store_we;
    logic [63:0]         bse64, rd_base, rd_end;
    mmrn_pkg::t_cmp_ctrl cmp_ctrl;
    logic [63:0]         em_base, em_len;
    logic [2:0]          em_kind;
    logic                em_last;
    logic                cap_ok;

    assign o_in_stall  = (r_state != mmrn_pkg::ST_IDLE);
    assign accept      = i_in_valid && (r_state == mmrn_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    assign bse64      = {32'd0, r_bse};
    assign load_ok    = !r_out_vld || !i_out_stall;
    assign scan_more  = r_scan_idx < r_seen_count;
    assign store_room = r_seen_count < SCW'(ENTRY_DEPTH);
    assign store_we   = (r_state == mmrn_pkg::ST_DECIDE) && store_room;
    assign cap_ok     = r_emit_cnt < ECW'(OUT_CAPACITY);

    assign cmp_ctrl.clear = accept;
    assign cmp_ctrl.vld   = r_cmp_vld;

    mmrn_entry_store #(
        .DEPTH (ENTRY_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (r_seen_count[AW-1:0]),
        .i_wbase (r_base),
        .i_wend  (r_end),
        .i_raddr (r_scan_idx[AW-1:0]),
        .o_rbase (rd_base),
        .o_rend  (rd_end)
    );

    mmrn_contain_unit u_contain (
        .i_clk       (i_clk),
        .i_ctrl      (cmp_ctrl),
        .i_seen_base (rd_base),
        .i_seen_end  (rd_end),
        .i_base      (r_base),
        .i_end       (r_end),
        .o_contained (contained)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mmrn_pkg::ST_IDLE: begin
                if (accept) n_state = mmrn_pkg::ST_SCAN;
            end
            mmrn_pkg::ST_SCAN: begin
                if (!scan_more) n_state = mmrn_pkg::ST_DECIDE;
            end
            mmrn_pkg::ST_DECIDE: begin
                n_state = contained ? mmrn_pkg::ST_IDLE : mmrn_pkg::ST_EMIT0;
            end
            mmrn_pkg::ST_EMIT0: begin
                if (load_ok) n_state = r_split ? mmrn_pkg::ST_EMIT1 : mmrn_pkg::ST_IDLE;
            end
            mmrn_pkg::ST_EMIT1: begin
                if (load_ok) n_state = mmrn_pkg::ST_IDLE;
            end
            default: n_state = mmrn_pkg::ST_IDLE;
        endcase
    end

    // region offered by the current emit state
    always_comb begin
        if (r_state == mmrn_pkg::ST_EMIT1) begin
            em_base = bse64;
            em_len  = r_len - r_delta;
            em_kind = mmrn_pkg::KIND_AVAIL;
            em_last = 1'b1;
        end else begin
            em_base = r_base;
            em_len  = r_split ? r_delta : r_len;
            em_kind = r_boot ? mmrn_pkg::KIND_BOOT : r_kind;
            em_last = !r_split;
        end
    end

    // datapath and counters
    always_comb begin
        n_seen_count = r_seen_count;
        n_emit_cnt   = r_emit_cnt;
        n_highest    = r_highest;
        n_scan_idx   = r_scan_idx;
        n_cmp_vld    = 1'b0;
        n_out_vld    = r_out_vld && i_out_stall;
        n_out        = r_out;
        n_flag       = r_flag;
        n_split      = r_split;
        n_boot       = r_boot;
        n_delta      = r_delta;
        case (r_state)
            mmrn_pkg::ST_IDLE: begin
                n_scan_idx = '0;
                if (accept && i_in_data.map_start) begin
                    n_seen_count = '0;
                    n_emit_cnt   = '0;
                end
            end
            mmrn_pkg::ST_SCAN: begin
                if (scan_more) begin
                    n_cmp_vld  = 1'b1;
                    n_scan_idx = r_scan_idx + 1'b1;
                end
            end
            mmrn_pkg::ST_DECIDE: begin
                n_flag = !store_room;
                if (store_room) n_seen_count = r_seen_count + 1'b1;
                if (!contained && (r_end > r_highest)) n_highest = r_end;
                n_boot  = (r_kind == mmrn_pkg::KIND_AVAIL) && (r_base < bse64);
                n_split = n_boot && (bse64 < r_end);
                n_delta = bse64 - r_base;
            end
            mmrn_pkg::ST_EMIT0, mmrn_pkg::ST_EMIT1: begin
                if (load_ok) begin
                    n_out_vld           = 1'b1;
                    n_out.out_base      = em_base;
                    n_out.out_length    = em_len;
                    n_out.out_kind      = em_kind;
                    n_out.highest_end   = r_highest;
                    n_out.last_of_run   = em_last;
                    n_out.out_index     = cap_ok ? 9'(r_emit_cnt) : 9'd0;
                    n_out.capacity_flag = r_flag || !cap_ok;
                    if (cap_ok) n_emit_cnt = r_emit_cnt + 1'b1;
                end
            end
            default: begin
                n_cmp_vld = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= mmrn_pkg::ST_IDLE;
            r_seen_count <= '0;
            r_emit_cnt   <= '0;
            r_highest    <= '0;
            r_bse        <= '0;
            r_scan_idx   <= '0;
            r_cmp_vld    <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_seen_count <= n_seen_count;
            r_emit_cnt   <= n_emit_cnt;
            r_highest    <= n_highest;
            r_scan_idx   <= n_scan_idx;
            r_cmp_vld    <= n_cmp_vld;
            r_out_vld    <= n_out_vld;
            if (i_cfg_valid && o_cfg_ready) r_bse <= i_cfg_data;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_base <= i_in_data.region_base;
            r_len  <= i_in_data.region_length;
            r_end  <= i_in_data.region_base + i_in_data.region_length;
            r_kind <= mmrn_pkg::kind_of(i_in_data.region_kind_in);
        end
        r_flag  <= n_flag;
        r_split <= n_split;
        r_boot  <= n_boot;
        r_delta <= n_delta;
        r_out   <= n_out;
    end

endmodule
